// ===== rtl/core/utfv_pkg.sv =====
// ----------------------------------------------------------------------------
// utfv_pkg
// Shared types and constants for the byte-serial UTF-8 validator and counter.
// ----------------------------------------------------------------------------
package utfv_pkg;

    // default width of the saturating character counters
    localparam int COUNT_BITS_DEF = 32;
    // width of the count fields on the result port
    localparam int OUT_BITS = 32;
    // entries in the queue between front and back
    localparam int Q_DEPTH = 2;

    // encoding reported in the summary
    typedef enum logic [2:0] {
        ENC_ASCII = 3'd0,
        ENC_UTF8  = 3'd1,
        ENC_U16LE = 3'd2,
        ENC_U16BE = 3'd3,
        ENC_U32LE = 3'd4,
        ENC_U32BE = 3'd5
    } t_enc;

    // summary status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2
    } t_status;

    // queue entry operation: check one byte, or close the buffer with no byte
    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_END   = 1'b1
    } t_op;

    // one queue entry from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
        logic       mark;
        t_enc       enc;
    } t_qent;

    // front sequencer states
    typedef enum logic [2:0] {
        F_COLLECT,
        F_DECIDE,
        F_REPLAY,
        F_PASS,
        F_SKIP,
        F_FINISH
    } t_fstate;

endpackage

// ===== rtl/core/utfv_queue.sv =====
// ----------------------------------------------------------------------------
// utfv_queue
// Small register queue that decouples the prefix front from the validator.
// ----------------------------------------------------------------------------
module utfv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utfv_pkg::t_qent  i_ent,
    output logic             o_full,
    output logic             o_valid,
    output utfv_pkg::t_qent  o_ent,
    input  logic             i_pop
);

    localparam int DEPTH = utfv_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    utfv_pkg::t_qent  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    // handshake qualifiers
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/utfv_front.sv =====
// ----------------------------------------------------------------------------
// utfv_front
// Accepts raw bytes, holds the first four, detects a byte order mark and
// feeds the validator queue with replayed and passed-through bytes.
// ----------------------------------------------------------------------------
module utfv_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_push,
    output utfv_pkg::t_qent  o_ent,
    input  logic             i_room
);

    // byte order mark bytes
    localparam logic [7:0] B_EF = 8'hEF;
    localparam logic [7:0] B_BB = 8'hBB;
    localparam logic [7:0] B_BF = 8'hBF;
    localparam logic [7:0] B_FF = 8'hFF;
    localparam logic [7:0] B_FE = 8'hFE;
    localparam logic [7:0] B_00 = 8'h00;

    utfv_pkg::t_fstate r_state, n_state;
    logic [2:0]        r_fill, n_fill;
    logic              r_last, n_last;
    logic              r_mark, n_mark;
    utfv_pkg::t_enc    r_enc, n_enc;
    logic [1:0]        r_idx, n_idx;
    logic [7:0]        r_store [4];

    logic              wr_store;
    logic              go_idle;
    logic              replay_more;
    logic              replay_final;
    logic              dec_mark;
    utfv_pkg::t_enc    dec_enc;
    logic [1:0]        dec_idx;

    // prefix store, written only while collecting
    always_ff @(posedge i_clk) begin
        if (wr_store) begin
            r_store[r_fill[1:0]] <= i_data_byte;
        end
    end

    // mark detection, in priority order
    always_comb begin
        dec_mark = 1'b0;
        dec_enc  = utfv_pkg::ENC_UTF8;
        dec_idx  = 2'd0;
        if (r_fill >= 3'd3 && r_store[0] == B_EF && r_store[1] == B_BB
                && r_store[2] == B_BF) begin
            dec_mark = 1'b1;
            dec_idx  = 2'd3;
        end else if (r_fill == 3'd4 && r_store[0] == B_FF && r_store[1] == B_FE
                && r_store[2] == B_00 && r_store[3] == B_00) begin
            dec_mark = 1'b1;
            dec_enc  = utfv_pkg::ENC_U32LE;
        end else if (r_fill == 3'd4 && r_store[0] == B_00 && r_store[1] == B_00
                && r_store[2] == B_FE && r_store[3] == B_FF) begin
            dec_mark = 1'b1;
            dec_enc  = utfv_pkg::ENC_U32BE;
        end else if (r_fill >= 3'd2 && r_store[0] == B_FF && r_store[1] == B_FE) begin
            dec_mark = 1'b1;
            dec_enc  = utfv_pkg::ENC_U16LE;
        end else if (r_fill >= 3'd2 && r_store[0] == B_FE && r_store[1] == B_FF) begin
            dec_mark = 1'b1;
            dec_enc  = utfv_pkg::ENC_U16BE;
        end
    end

    assign replay_more  = ({1'b0, r_idx} < r_fill);
    assign replay_final = (({1'b0, r_idx} + 3'd1) == r_fill);

    // next state and queue feed
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_last     = r_last;
        n_mark     = r_mark;
        n_enc      = r_enc;
        n_idx      = r_idx;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        o_ent.op   = utfv_pkg::OP_CHECK;
        o_ent.data = i_data_byte;
        o_ent.last = i_last_byte;
        o_ent.mark = r_mark;
        o_ent.enc  = r_enc;
        wr_store   = 1'b0;
        go_idle    = 1'b0;
        case (r_state)
            utfv_pkg::F_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    wr_store = 1'b1;
                    n_fill   = r_fill + 3'd1;
                    n_last   = i_last_byte;
                    if (r_fill == 3'd3 || i_last_byte) begin
                        n_state = utfv_pkg::F_DECIDE;
                    end
                end
            end
            utfv_pkg::F_DECIDE: begin
                n_mark = dec_mark;
                n_enc  = dec_enc;
                n_idx  = dec_idx;
                if (dec_enc != utfv_pkg::ENC_UTF8) begin
                    n_state = r_last ? utfv_pkg::F_FINISH : utfv_pkg::F_SKIP;
                end else begin
                    n_state = utfv_pkg::F_REPLAY;
                end
            end
            utfv_pkg::F_REPLAY: begin
                o_push = 1'b1;
                if (replay_more) begin
                    o_ent.data = r_store[r_idx];
                    o_ent.last = r_last && replay_final;
                    if (i_room) begin
                        n_idx = r_idx + 2'd1;
                        if (replay_final) begin
                            if (r_last) begin
                                go_idle = 1'b1;
                            end else begin
                                n_state = utfv_pkg::F_PASS;
                            end
                        end
                    end
                end else begin
                    // mark filled the whole buffer: close it with no byte
                    o_ent.op   = utfv_pkg::OP_END;
                    o_ent.last = 1'b1;
                    go_idle    = i_room;
                end
            end
            utfv_pkg::F_PASS: begin
                o_in_ready = i_room;
                o_push     = i_in_valid;
                go_idle    = i_in_valid && i_room && i_last_byte;
            end
            utfv_pkg::F_SKIP: begin
                // foreign encoding: drop bytes until the buffer ends
                o_in_ready = i_room;
                o_push     = i_in_valid && i_last_byte;
                o_ent.op   = utfv_pkg::OP_END;
                o_ent.last = 1'b1;
                go_idle    = i_in_valid && i_room && i_last_byte;
            end
            utfv_pkg::F_FINISH: begin
                o_push     = 1'b1;
                o_ent.op   = utfv_pkg::OP_END;
                o_ent.last = 1'b1;
                go_idle    = i_room;
            end
            default: begin
                n_state = utfv_pkg::F_COLLECT;
            end
        endcase
        if (go_idle) begin
            n_state = utfv_pkg::F_COLLECT;
            n_fill  = 3'd0;
            n_mark  = 1'b0;
            n_enc   = utfv_pkg::ENC_UTF8;
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utfv_pkg::F_COLLECT;
            r_fill  <= 3'd0;
            r_last  <= 1'b0;
            r_mark  <= 1'b0;
            r_enc   <= utfv_pkg::ENC_UTF8;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_last  <= n_last;
            r_mark  <= n_mark;
            r_enc   <= n_enc;
            r_idx   <= n_idx;
        end
    end

`ifndef SYNTH
    // an empty replay only happens when the mark ended the buffer
    a_empty_replay_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utfv_pkg::F_REPLAY && !replay_more) |-> r_last)
        else $error("empty replay without final byte");

    // the decision sees a full prefix or a short buffer, never nothing
    a_decide_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utfv_pkg::F_DECIDE) |-> (r_fill != 3'd0 && (r_fill == 3'd4 || r_last)))
        else $error("prefix decision on bad fill");
`endif

endmodule

// ===== rtl/core/utfv_back.sv =====
// ----------------------------------------------------------------------------
// utfv_back
// UTF-8 sequence checker with saturating length counters and the summary
// output register.
// ----------------------------------------------------------------------------
module utfv_back #(
    parameter int COUNT_BITS = utfv_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  utfv_pkg::t_qent               i_q_ent,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [2:0]                    o_encoding_kind,
    output logic                          o_bom_present,
    output logic                          o_null_terminated,
    output logic [utfv_pkg::OUT_BITS-1:0] o_char_count,
    output logic [utfv_pkg::OUT_BITS-1:0] o_one_byte_count,
    output logic [utfv_pkg::OUT_BITS-1:0] o_two_byte_count,
    output logic [utfv_pkg::OUT_BITS-1:0] o_three_byte_count,
    output logic [utfv_pkg::OUT_BITS-1:0] o_four_byte_count
);

    localparam int OB = utfv_pkg::OUT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;

    // sequence length from a lead byte, zero for a byte that cannot lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

    logic [2:0]             r_seq_len, n_seq_len;
    logic [2:0]             r_seq_pos, n_seq_pos;
    logic [20:0]            r_acc, n_acc;
    logic                   r_pend, n_pend;
    utfv_pkg::t_status      r_err, n_err;
    logic                   r_null, n_null;
    logic [COUNT_BITS-1:0]  r_cnt [5];
    logic [COUNT_BITS-1:0]  n_cnt [5];

    // values after this byte, before the end-of-buffer clear
    logic [2:0]             s_seq_len, s_seq_pos;
    logic [20:0]            s_acc;
    logic                   s_pend;
    utfv_pkg::t_status      s_err;
    logic                   s_null;
    logic [COUNT_BITS-1:0]  s_cnt [5];

    logic                   r_ovalid;
    utfv_pkg::t_status      r_status;
    utfv_pkg::t_enc         r_enc;
    logic                   r_bom;
    logic                   r_nul_t;
    logic [OB-1:0]          r_ocnt [5];

    logic                   pop;
    logic                   is_last;
    logic                   foreign;
    logic [2:0]             lead;
    logic [20:0]            code;
    logic [2:0]             pos_inc;
    logic                   bad;
    logic                   do_acc;
    logic [2:0]             acc_len;
    logic [4:0]             inc;
    utfv_pkg::t_status      sum_status;
    utfv_pkg::t_enc         sum_enc;
    logic                   sum_null;

    // the output register frees the queue once the summary is taken
    assign pop     = i_q_valid && (!r_ovalid || i_out_ready);
    assign o_q_pop = pop;
    assign is_last = pop && (i_q_ent.op == utfv_pkg::OP_END || i_q_ent.last);
    assign foreign = (i_q_ent.op == utfv_pkg::OP_END) && (i_q_ent.enc != utfv_pkg::ENC_UTF8);
    assign lead    = lead_length(i_q_ent.data);
    assign code    = {r_acc[14:0], i_q_ent.data[5:0]};
    assign pos_inc = r_seq_pos + 3'd1;

    // sequence checking for one byte
    always_comb begin
        s_seq_len = r_seq_len;
        s_seq_pos = r_seq_pos;
        s_acc     = r_acc;
        s_pend    = r_pend;
        s_err     = r_err;
        s_null    = r_null;
        do_acc    = 1'b0;
        acc_len   = 3'd0;
        bad       = 1'b0;
        if (pop && i_q_ent.op == utfv_pkg::OP_CHECK && r_err == utfv_pkg::ST_OK) begin
            if (r_seq_len == 3'd0) begin
                if (lead == 3'd1) begin
                    if (i_q_ent.data == 8'h00 && i_q_ent.last) begin
                        s_null = 1'b1;
                    end else begin
                        do_acc  = 1'b1;
                        acc_len = 3'd1;
                    end
                end else if (lead == 3'd0) begin
                    s_err = utfv_pkg::ST_INVALID;
                end else if (i_q_ent.last) begin
                    s_err = utfv_pkg::ST_TRUNC;
                end else begin
                    s_seq_len = lead;
                    s_seq_pos = 3'd1;
                    s_pend    = 1'b0;
                    if (lead == 3'd2) begin
                        s_acc = {16'd0, i_q_ent.data[4:0]};
                    end else if (lead == 3'd3) begin
                        s_acc = {17'd0, i_q_ent.data[3:0]};
                    end else begin
                        s_acc = {18'd0, i_q_ent.data[2:0]};
                    end
                end
            end else begin
                s_pend    = r_pend || (i_q_ent.data[7:6] != 2'b10);
                s_acc     = code;
                s_seq_pos = pos_inc;
                if (pos_inc >= r_seq_len) begin
                    bad = s_pend || (code > CP_MAX)
                        || (code inside {[SURR_LO:SURR_HI]})
                        || (r_seq_len == 3'd2 && code < MIN_TWO)
                        || (r_seq_len == 3'd3 && code < MIN_THREE)
                        || (r_seq_len == 3'd4 && code < MIN_FOUR);
                    s_seq_len = 3'd0;
                    s_seq_pos = 3'd0;
                    s_pend    = 1'b0;
                    if (bad) begin
                        s_err = utfv_pkg::ST_INVALID;
                    end else begin
                        do_acc  = 1'b1;
                        acc_len = r_seq_len;
                    end
                end else if (i_q_ent.last) begin
                    s_err = utfv_pkg::ST_TRUNC;
                end
            end
        end
    end

    // saturating counters
    always_comb begin
        inc[0] = do_acc;
        inc[1] = do_acc && (acc_len == 3'd1);
        inc[2] = do_acc && (acc_len == 3'd2);
        inc[3] = do_acc && (acc_len == 3'd3);
        inc[4] = do_acc && (acc_len == 3'd4);
        for (int k = 0; k < 5; k++) begin
            s_cnt[k] = (inc[k] && r_cnt[k] != CNT_MAX) ? r_cnt[k] + COUNT_BITS'(1) : r_cnt[k];
        end
    end

    // summary fields and end-of-buffer clear
    always_comb begin
        sum_status = foreign ? utfv_pkg::ST_OK : s_err;
        if (foreign) begin
            sum_enc = i_q_ent.enc;
        end else if (s_err == utfv_pkg::ST_OK && s_cnt[1] == s_cnt[0]) begin
            sum_enc = utfv_pkg::ENC_ASCII;
        end else begin
            sum_enc = utfv_pkg::ENC_UTF8;
        end
        sum_null  = !foreign && (s_err == utfv_pkg::ST_OK) && s_null;

        n_seq_len = is_last ? 3'd0 : s_seq_len;
        n_seq_pos = is_last ? 3'd0 : s_seq_pos;
        n_acc     = is_last ? 21'd0 : s_acc;
        n_pend    = is_last ? 1'b0 : s_pend;
        n_err     = is_last ? utfv_pkg::ST_OK : s_err;
        n_null    = is_last ? 1'b0 : s_null;
        for (int k = 0; k < 5; k++) begin
            n_cnt[k] = is_last ? '0 : s_cnt[k];
        end
    end

    // checker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= 3'd0;
            r_seq_pos <= 3'd0;
            r_acc     <= 21'd0;
            r_pend    <= 1'b0;
            r_err     <= utfv_pkg::ST_OK;
            r_null    <= 1'b0;
            for (int k = 0; k < 5; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_seq_len <= n_seq_len;
            r_seq_pos <= n_seq_pos;
            r_acc     <= n_acc;
            r_pend    <= n_pend;
            r_err     <= n_err;
            r_null    <= n_null;
            for (int k = 0; k < 5; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (is_last) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (is_last) begin
            r_status <= sum_status;
            r_enc    <= sum_enc;
            r_bom    <= i_q_ent.mark;
            r_nul_t  <= sum_null;
            for (int k = 0; k < 5; k++) begin
                r_ocnt[k] <= OB'(s_cnt[k]);
            end
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_status           = r_status;
    assign o_encoding_kind    = r_enc;
    assign o_bom_present      = r_bom;
    assign o_null_terminated  = r_nul_t;
    assign o_char_count       = r_ocnt[0];
    assign o_one_byte_count   = r_ocnt[1];
    assign o_two_byte_count   = r_ocnt[2];
    assign o_three_byte_count = r_ocnt[3];
    assign o_four_byte_count  = r_ocnt[4];

`ifndef SYNTH
    // an open sequence is multi-byte and not yet complete
    a_seq_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_len != 3'd0) |-> (r_seq_len >= 3'd2 && r_seq_pos != 3'd0
            && r_seq_pos < r_seq_len))
        else $error("sequence position out of range");

    // the total never falls behind the one-byte count
    a_total_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] >= r_cnt[1])
        else $error("character total below one-byte count");

    // a summary leaves the checker clean for the next buffer
    a_clean_after_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_last |=> (r_ovalid && r_seq_len == 3'd0 && r_err == utfv_pkg::ST_OK
            && !r_null && r_cnt[0] == '0))
        else $error("state not cleared after summary");
`endif

endmodule

// ===== rtl/core/utf8_validate_and_count.sv =====
// ----------------------------------------------------------------------------
// utf8_validate_and_count
// Byte-serial UTF-8 validator with byte order mark detection and per-length
// character counts; one summary per buffer.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_data_byte, i_last_byte
//  out      source     o_out_valid / i_out_ready  o_status .. o_four_byte_count
//
//  Past the prefix, one byte per cycle flows through the two-entry queue unless
//  the summary stalls. A buffer's first up to four bytes are held, the mark is
//  decided and the held bytes replay one per cycle while the queue has room,
//  with no byte taken meanwhile. The summary is registered on the last pop.
//  Reset (synchronous, active low) returns to the start of a new buffer.
//  A stalled summary blocks the checker, and the queue then backs up input.
// ----------------------------------------------------------------------------
module utf8_validate_and_count #(
    parameter int COUNT_BITS = utfv_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [2:0]                    o_encoding_kind,
    output logic                          o_bom_present,
    output logic                          o_null_terminated,
    output logic [utfv_pkg::OUT_BITS-1:0] o_char_count,
    output logic [utfv_pkg::OUT_BITS-1:0] o_one_byte_count,
    output logic [utfv_pkg::OUT_BITS-1:0] o_two_byte_count,
    output logic [utfv_pkg::OUT_BITS-1:0] o_three_byte_count,
    output logic [utfv_pkg::OUT_BITS-1:0] o_four_byte_count
);

    logic            push;
    utfv_pkg::t_qent push_ent;
    logic            q_full;
    logic            q_valid;
    utfv_pkg::t_qent q_ent;
    logic            q_pop;

    // prefix handling and byte routing
    utfv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_ent       (push_ent),
        .i_room      (!q_full)
    );

    // decoupling queue
    utfv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (q_pop)
    );

    // sequence checker, counters and summary register
    utfv_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_ent            (q_ent),
        .o_q_pop            (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_encoding_kind    (o_encoding_kind),
        .o_bom_present      (o_bom_present),
        .o_null_terminated  (o_null_terminated),
        .o_char_count       (o_char_count),
        .o_one_byte_count   (o_one_byte_count),
        .o_two_byte_count   (o_two_byte_count),
        .o_three_byte_count (o_three_byte_count),
        .o_four_byte_count  (o_four_byte_count)
    );

endmodule

// ===== tb/utf8_validate_and_count_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_validate_and_count_test
// Feeds byte buffers into the validator: a handful of hand-picked buffers
// covering every byte order mark, the error kinds and the final NUL, then a
// long run of random buffers, mostly well-formed text with random content
// and some noise, broken and cut-short sequences. A scoreboard class keeps
// its own model of the scan and checks every summary field by field. Input
// comes in bursts with gaps, output stalls on changing patterns, and once in
// a while output holds off long enough to back the input up.
// ----------------------------------------------------------------------------
module utf8_validate_and_count_test;
    import utfv_pkg::*;

    localparam int RANDOM_BYTES  = 1600;
    localparam int LONG_HOLD     = 400;
    localparam int REPORT_LIMIT  = 10;

    // one buffer summary as seen on the result port
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  enc;
        logic        bom;
        logic        nul;
        logic [31:0] chars;
        logic [31:0] len1;
        logic [31:0] len2;
        logic [31:0] len3;
        logic [31:0] len4;
    } summary_t;

    // where the scan of the current buffer stands
    typedef enum {
        SCAN_PREFIX,
        SCAN_BODY,
        SCAN_SKIP
    } scan_phase_t;

    // ------------------------------------------------------------------------
    // scoreboard: tracks the scan per byte and checks summaries in order
    // ------------------------------------------------------------------------
    class utf8_summary_board;
        bit [7:0]    held [4];
        int unsigned held_fill;
        scan_phase_t phase;
        int unsigned seq_len;
        int unsigned seq_pos;
        bit [20:0]   code;
        bit          pend_bad;
        t_status     err;
        t_enc        enc_found;
        bit          mark;
        bit          nul_end;
        bit [31:0]   tally [5];
        summary_t    expected_q [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            foreach (held[i]) held[i] = 8'h00;
            held_fill = 0;
            phase     = SCAN_PREFIX;
            seq_len   = 0;
            seq_pos   = 0;
            code      = '0;
            pend_bad  = 1'b0;
            err       = ST_OK;
            enc_found = ENC_UTF8;
            mark      = 1'b0;
            nul_end   = 1'b0;
            foreach (tally[i]) tally[i] = '0;
        endfunction

        function int unsigned lead_len(bit [7:0] b);
            if (b[7] == 1'b0) return 1;
            if (b[7:5] == 3'b110) return 2;
            if (b[7:4] == 4'b1110) return 3;
            if (b[7:3] == 5'b11110) return 4;
            return 0;
        endfunction

        // saturating counts: slot 0 all characters, slots 1..4 by length
        function void count_char(int unsigned len);
            if (tally[0] != '1) tally[0]++;
            if (tally[len] != '1) tally[len]++;
        endfunction

        function void feed(bit [7:0] b, bit last);
            int unsigned n;
            bit bad;
            if (err != ST_OK) return;
            // character start
            if (seq_len == 0) begin
                n = lead_len(b);
                if (n == 1) begin
                    if (b == 8'h00 && last) nul_end = 1'b1;
                    else count_char(1);
                end else if (n == 0) begin
                    err = ST_INVALID;
                end else if (last) begin
                    err = ST_TRUNC;
                end else begin
                    seq_len  = n;
                    seq_pos  = 1;
                    pend_bad = 1'b0;
                    case (n)
                        2: code = {16'd0, b[4:0]};
                        3: code = {17'd0, b[3:0]};
                        default: code = {18'd0, b[2:0]};
                    endcase
                end
                return;
            end
            // continuation byte
            if (b[7:6] != 2'b10) pend_bad = 1'b1;
            code = {code[14:0], b[5:0]};
            seq_pos++;
            if (seq_pos >= seq_len) begin
                bad = pend_bad || code > 21'h10FFFF ||
                      (code >= 21'h00D800 && code <= 21'h00DFFF) ||
                      (seq_len == 2 && code < 21'h000080) ||
                      (seq_len == 3 && code < 21'h000800) ||
                      (seq_len == 4 && code < 21'h010000);
                n        = seq_len;
                seq_len  = 0;
                seq_pos  = 0;
                pend_bad = 1'b0;
                if (bad) err = ST_INVALID;
                else count_char(n);
            end else if (last) begin
                err = ST_TRUNC;
            end
        endfunction

        // mark decision over the held bytes, then replay of what is left
        function void settle_prefix(bit last);
            int unsigned skip;
            skip = 0;
            if (held_fill >= 3 && held[0] == 8'hEF && held[1] == 8'hBB && held[2] == 8'hBF)
            begin
                mark = 1'b1;
                skip = 3;
            end else if (held_fill >= 4 && held[0] == 8'hFF && held[1] == 8'hFE &&
                         held[2] == 8'h00 && held[3] == 8'h00) begin
                mark      = 1'b1;
                enc_found = ENC_U32LE;
            end else if (held_fill >= 4 && held[0] == 8'h00 && held[1] == 8'h00 &&
                         held[2] == 8'hFE && held[3] == 8'hFF) begin
                mark      = 1'b1;
                enc_found = ENC_U32BE;
            end else if (held_fill >= 2 && held[0] == 8'hFF && held[1] == 8'hFE) begin
                mark      = 1'b1;
                enc_found = ENC_U16LE;
            end else if (held_fill >= 2 && held[0] == 8'hFE && held[1] == 8'hFF) begin
                mark      = 1'b1;
                enc_found = ENC_U16BE;
            end
            if (enc_found != ENC_UTF8) begin
                phase = SCAN_SKIP;
                return;
            end
            phase = SCAN_BODY;
            for (int unsigned i = skip; i < held_fill; i++)
                feed(held[i], last && (i + 1 == held_fill));
        endfunction

        // one input transfer
        function void note_byte(bit [7:0] b, bit last);
            summary_t s;
            case (phase)
                SCAN_PREFIX: begin
                    if (held_fill < 4) begin
                        held[held_fill] = b;
                        held_fill++;
                    end
                    if (held_fill >= 4 || last) settle_prefix(last);
                end
                SCAN_BODY: feed(b, last);
                default: ;
            endcase
            if (!last) return;
            // buffer closed: build its summary
            s.status = ST_OK;
            s.enc    = enc_found;
            if (phase != SCAN_SKIP) begin
                s.status = err;
                s.enc    = ENC_UTF8;
                if (err == ST_OK && tally[1] == tally[0]) s.enc = ENC_ASCII;
            end
            s.bom   = mark;
            s.nul   = (phase != SCAN_SKIP) && (err == ST_OK) && nul_end;
            s.chars = tally[0];
            s.len1  = tally[1];
            s.len2  = tally[2];
            s.len3  = tally[3];
            s.len4  = tally[4];
            expected_q.push_back(s);
            clear();
        endfunction

        function void compare_field(string name, bit [31:0] want, bit [31:0] got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $realtime, name, want, got);
            end
        endfunction

        // one output transfer against the oldest waiting summary
        function void check_summary(summary_t got);
            summary_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: summary with none expected, actual %0h", $realtime, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("encoding_kind", 32'(want.enc), 32'(got.enc));
            compare_field("bom_present", 32'(want.bom), 32'(got.bom));
            compare_field("null_terminated", 32'(want.nul), 32'(got.nul));
            compare_field("char_count", want.chars, got.chars);
            compare_field("one_byte_count", want.len1, got.len1);
            compare_field("two_byte_count", want.len2, got.len2);
            compare_field("three_byte_count", want.len3, got.len3);
            compare_field("four_byte_count", want.len4, got.len4);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_data_byte;
    logic                 i_last_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_status;
    logic [2:0]           o_encoding_kind;
    logic                 o_bom_present;
    logic                 o_null_terminated;
    logic [OUT_BITS-1:0]  o_char_count;
    logic [OUT_BITS-1:0]  o_one_byte_count;
    logic [OUT_BITS-1:0]  o_two_byte_count;
    logic [OUT_BITS-1:0]  o_three_byte_count;
    logic [OUT_BITS-1:0]  o_four_byte_count;

    utf8_summary_board board = new();
    bit [7:0]          frame [$];
    int unsigned       sent_bytes = 0;
    int unsigned       burst_left = 0;
    bit                burst_quiet = 1'b0;
    bit                hold_request = 1'b0;

    utf8_validate_and_count dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    task automatic send_byte(bit [7:0] b, bit last);
        int unsigned gap;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        board.note_byte(b, last);
        sent_bytes++;
        // bursts with random gaps, some stretches with no gaps at all
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_quiet = ($urandom_range(0, 3) == 0);
            burst_left  = burst_quiet ? $urandom_range(30, 120) : $urandom_range(0, 12);
            gap         = burst_quiet ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    // append code point cp encoded in len bytes, overlong or out of range allowed
    function automatic void put_code(int unsigned cp, int unsigned len);
        case (len)
            1: frame.push_back(cp[7:0]);
            2: begin
                frame.push_back({3'b110, cp[10:6]});
                frame.push_back({2'b10, cp[5:0]});
            end
            3: begin
                frame.push_back({4'b1110, cp[15:12]});
                frame.push_back({2'b10, cp[11:6]});
                frame.push_back({2'b10, cp[5:0]});
            end
            default: begin
                frame.push_back({5'b11110, cp[20:18]});
                frame.push_back({2'b10, cp[17:12]});
                frame.push_back({2'b10, cp[11:6]});
                frame.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // legal code point for a given length, range ends favored
    function automatic int unsigned pick_code(int unsigned len);
        int unsigned lo;
        int unsigned hi;
        int unsigned cp;
        int unsigned r;
        case (len)
            1: begin lo = 'h0;     hi = 'h7F;     end
            2: begin lo = 'h80;    hi = 'h7FF;    end
            3: begin lo = 'h800;   hi = 'hFFFF;   end
            default: begin lo = 'h10000; hi = 'h10FFFF; end
        endcase
        r  = $urandom_range(0, 7);
        cp = (r == 0) ? lo : (r == 1) ? hi : $urandom_range(lo, hi);
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp - 'h800;
        return cp;
    endfunction

    function automatic void put_char(int unsigned len);
        put_code(pick_code(len), len);
    endfunction

    function automatic bit [7:0] non_continuation();
        bit [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        return b;
    endfunction

    // one malformed item: stray or bad lead, overlong, surrogate, too large,
    // or a broken continuation
    function automatic void put_broken();
        int unsigned len;
        int unsigned at;
        case ($urandom_range(0, 5))
            0: frame.push_back(8'($urandom_range(8'h80, 8'hBF)));
            1: frame.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            2: begin
                len = $urandom_range(2, 4);
                put_code($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF),
                         len);
            end
            3: put_code($urandom_range('hD800, 'hDFFF), 3);
            4: put_code($urandom_range('h110000, 'h1FFFFF), 4);
            default: begin
                len = $urandom_range(2, 4);
                put_char(len);
                at = frame.size() - $urandom_range(1, len - 1);
                frame[at] = non_continuation();
            end
        endcase
    endfunction

    // leading part of a multi-byte character, sometimes with a bad byte in it
    function automatic void put_cut_short();
        int unsigned len;
        int unsigned keep;
        int unsigned base;
        len  = $urandom_range(2, 4);
        keep = $urandom_range(1, len - 1);
        base = frame.size();
        put_char(len);
        while (frame.size() > base + keep) void'(frame.pop_back());
        if (keep >= 2 && $urandom_range(0, 2) == 0)
            frame[base + $urandom_range(1, keep - 1)] = non_continuation();
    endfunction

    // random buffer: optional mark or mark fragment, then a body
    task automatic build_random_frame();
        int unsigned style;
        int unsigned nchar;
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r >= 12 && r <= 14) frame = {8'hEF, 8'hBB, 8'hBF};
        else if (r == 15) frame = {8'hFF, 8'hFE};
        else if (r == 16) frame = {8'hFE, 8'hFF};
        else if (r == 17) frame = {8'hFF, 8'hFE, 8'h00, 8'h00};
        else if (r == 18) frame = {8'h00, 8'h00, 8'hFE, 8'hFF};
        else if (r == 19) begin
            case ($urandom_range(0, 3))
                0: frame = {8'hEF, 8'hBB};
                1: frame = {8'hFF, 8'hFE, 8'h00};
                2: frame = {8'hEF};
                default: frame = {8'h00, 8'h00, 8'hFE};
            endcase
        end
        style = $urandom_range(0, 9);
        nchar = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
        for (int k = 0; k < nchar; k++) begin
            if (style == 9) frame.push_back(8'($urandom_range(0, 255)));
            else put_char((style <= 3) ? 1 : $urandom_range(1, 4));
        end
        if (style != 9) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    put_broken();
                    repeat ($urandom_range(0, 3)) put_char($urandom_range(1, 4));
                end
                2: put_cut_short();
                3: frame.push_back(8'h00);
                default: ;
            endcase
        end
        if (frame.size() == 0) frame.push_back(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned guard;
        bit first_hold_done;
        bit second_hold_done;
        first_hold_done  = 1'b0;
        second_hold_done = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone final NUL
        frame = {8'h00};
        send_frame();
        // each non-UTF-8 mark, short and long forms
        frame = {8'hFE, 8'hFF};
        send_frame();
        frame = {8'hFF, 8'hFE, 8'h00, 8'h00};
        send_frame();
        frame = {8'h00, 8'h00, 8'hFE, 8'hFF};
        send_frame();
        frame = {8'hFF, 8'hFE, 8'h41};
        send_frame();
        // UTF-8 mark skipped, ASCII maximum after it
        frame = {8'hEF, 8'hBB, 8'hBF, 8'h7F};
        send_frame();
        // overlong two-byte form
        frame = {8'hC0, 8'h80};
        send_frame();
        // cut-short sequence with a bad byte inside reports truncated
        frame = {8'hE2, 8'h41};
        send_frame();
        // four-byte character, then final NUL
        frame = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00};
        send_frame();

        // random buffers
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            if (!first_hold_done && sent_bytes >= 400) begin
                hold_request    = 1'b1;
                first_hold_done = 1'b1;
            end
            if (!second_hold_done && sent_bytes >= 1100) begin
                hold_request     = 1'b1;
                second_hold_done = 1'b1;
            end
            build_random_frame();
            send_frame();
        end
        i_in_valid <= 1'b0;

        // drain
        guard = 0;
        while (board.pending() > 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver side: checks transfers and stalls on changing patterns
    // ------------------------------------------------------------------------
    initial begin
        summary_t    got;
        int unsigned hold_left;
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                got.status = o_status;
                got.enc    = o_encoding_kind;
                got.bom    = o_bom_present;
                got.nul    = o_null_terminated;
                got.chars  = o_char_count;
                got.len1   = o_one_byte_count;
                got.len2   = o_two_byte_count;
                got.len3   = o_three_byte_count;
                got.len4   = o_four_byte_count;
                board.check_summary(got);
            end
            // long hold-off so the input backs up
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= (tick % 4 == 0);
                    default: i_out_ready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

endmodule

// ===== utf8_validate_and_count.f =====
rtl/core/utfv_pkg.sv
rtl/core/utfv_queue.sv
rtl/core/utfv_front.sv
rtl/core/utfv_back.sv
rtl/core/utf8_validate_and_count.sv
tb/utf8_validate_and_count_test.sv
